[rtl/sdio_split_pkg.sv]
// Shared types and constants for the SDIO transfer splitter.
// No dependencies; imported by every module of the block.
package sdio_split_pkg;

  localparam int unsigned FUNC_W   = 3;
  localparam int unsigned ADDR_W   = 17;
  localparam int unsigned COUNT_W  = 20;
  localparam int unsigned BLKCNT_W = 9;
  localparam int unsigned UNIT_W   = 10;

  localparam int unsigned IN_DATA_W  = 48;
  localparam int unsigned OUT_DATA_W = 64;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [FUNC_W-1:0]   FUNC_BIG_BLOCK = 3'd2;
  localparam logic [UNIT_W-1:0]   BSIZE_BIG      = 10'd512;
  localparam logic [UNIT_W-1:0]   BSIZE_SMALL    = 10'd64;
  localparam logic [BLKCNT_W-1:0] BLOCK_CAP      = 9'd511;

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic               wr;
    logic [ADDR_W-1:0]  addr;
    logic               incr;
    logic [COUNT_W-1:0] count;
    logic               big;
    logic               blk_mode;
  } req_t;

  typedef struct packed {
    logic                wr;
    logic [FUNC_W-1:0]   func;
    logic [ADDR_W-1:0]   addr;
    logic                incr;
    logic [BLKCNT_W-1:0] blocks;
    logic [UNIT_W-1:0]   unit;
    logic [COUNT_W-1:0]  offset;
    logic                last;
  } cmd_t;

endpackage

[rtl/sdio_split_front.sv]
// Request intake: accepts and classifies requests, queues them for the back end.
// Depends on sdio_split_pkg.
module sdio_split_front #(
  parameter int unsigned QueueDepth = sdio_split_pkg::QUEUE_DEPTH
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [sdio_split_pkg::IN_DATA_W-1:0] s_axis_tdata,
  output logic                                q_valid_o,
  output sdio_split_pkg::req_t                q_data_o,
  input  logic                                q_pop_i
);
  import sdio_split_pkg::*;

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  req_t             mem_q [QueueDepth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  cnt_q;
  req_t             req;
  logic [UNIT_W-1:0] bsize;
  logic             push;

  always_comb begin
    req.func     = s_axis_tdata[2:0];
    req.wr       = s_axis_tdata[3];
    req.addr     = s_axis_tdata[20:4];
    req.incr     = s_axis_tdata[21];
    req.count    = s_axis_tdata[41:22];
    req.big      = (req.func == FUNC_BIG_BLOCK);
    bsize        = req.big ? BSIZE_BIG : BSIZE_SMALL;
    req.blk_mode = (req.count > COUNT_W'(bsize));
  end

  assign s_axis_tready = (cnt_q != CntW'(QueueDepth));
  // drop zero-length requests
  assign push      = s_axis_tvalid && s_axis_tready && (req.count != '0);
  assign q_valid_o = (cnt_q != '0);
  assign q_data_o  = mem_q[rd_ptr_q];

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(QueueDepth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) wr_ptr_q <= ptr_inc(wr_ptr_q);
      if (q_pop_i) rd_ptr_q <= ptr_inc(rd_ptr_q);
      if (push && !q_pop_i) cnt_q <= cnt_q + CntW'(1);
      else if (!push && q_pop_i) cnt_q <= cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= req;
  end

endmodule

[rtl/sdio_split_back.sv]
// Command sequencer: splits one queued request into CMD53-style commands.
// Depends on sdio_split_pkg.
module sdio_split_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_valid_i,
  input  sdio_split_pkg::req_t q_data_i,
  output logic                 q_pop_o,
  output logic                 cmd_valid_o,
  input  logic                 cmd_ready_i,
  output sdio_split_pkg::cmd_t cmd_o
);
  import sdio_split_pkg::*;

  typedef enum logic {ST_IDLE, ST_RUN} state_e;

  state_e             state_q;
  req_t               req_q;
  logic [COUNT_W-1:0] left_q;
  logic [ADDR_W-1:0]  addr_q;
  logic [COUNT_W-1:0] off_q;
  logic               valid_q;
  cmd_t               cmd_q;

  logic                load_en;
  logic [UNIT_W-1:0]   bsize;
  logic                use_blocks;
  logic [13:0]         raw_blocks;
  logic [BLKCNT_W-1:0] blocks;
  logic [COUNT_W-1:0]  moved;
  cmd_t                next_cmd;

  assign load_en = !valid_q || cmd_ready_i;
  assign q_pop_o = (state_q == ST_IDLE) && q_valid_i;

  always_comb begin
    bsize      = req_q.big ? BSIZE_BIG : BSIZE_SMALL;
    use_blocks = req_q.blk_mode && (left_q >= COUNT_W'(bsize));
    raw_blocks = req_q.big ? {3'd0, left_q[19:9]} : left_q[19:6];
    blocks     = (raw_blocks > 14'(BLOCK_CAP)) ? BLOCK_CAP : raw_blocks[BLKCNT_W-1:0];
    if (use_blocks) begin
      moved = req_q.big ? {2'd0, blocks, 9'd0} : {5'd0, blocks, 6'd0};
    end else begin
      moved = left_q;
    end
    next_cmd.wr     = req_q.wr;
    next_cmd.func   = req_q.func;
    next_cmd.addr   = addr_q;
    next_cmd.incr   = req_q.incr;
    next_cmd.blocks = use_blocks ? blocks : '0;
    next_cmd.unit   = use_blocks ? bsize : left_q[UNIT_W-1:0];
    next_cmd.offset = off_q;
    next_cmd.last   = (moved == left_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      valid_q <= 1'b0;
      req_q   <= '0;
      left_q  <= '0;
      addr_q  <= '0;
      off_q   <= '0;
      cmd_q   <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (load_en) valid_q <= 1'b0;
          if (q_valid_i) begin
            req_q   <= q_data_i;
            left_q  <= q_data_i.count;
            addr_q  <= q_data_i.addr;
            off_q   <= '0;
            state_q <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (load_en) begin
            valid_q <= 1'b1;
            cmd_q   <= next_cmd;
            left_q  <= left_q - moved;
            off_q   <= off_q + moved;
            if (req_q.incr) addr_q <= addr_q + moved[ADDR_W-1:0];
            if (next_cmd.last) state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign cmd_valid_o = valid_q;
  assign cmd_o       = cmd_q;

endmodule

[rtl/sdio_transfer_splitter.sv]
// SDIO transfer splitter top level: request queue front end and command sequencer.
// A request passes the queue, the sequencer request register and the command register.
// Throughput: one command per cycle while the sink is ready, set by the sequencer;
// a request splits into at most 34 commands; the sequencer idles between requests.
// Reset: asynchronous, active low; clears the queue, sequencer state and output valid.
// Depends on sdio_split_pkg, sdio_split_front, sdio_split_back.
module sdio_transfer_splitter #(
  parameter int unsigned QueueDepth = sdio_split_pkg::QUEUE_DEPTH
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // [2:0] func_num, [3] is_write, [20:4] start_addr, [21] inc_flag,
  // [41:22] byte_count, [47:42] zero
  input  logic [sdio_split_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // [0] cmd_write, [3:1] cmd_func, [20:4] cmd_addr, [21] cmd_incr,
  // [30:22] block_count, [40:31] unit_size, [60:41] buffer_offset, [63:61] zero
  output logic [sdio_split_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  output logic                                 m_axis_tlast
);
  import sdio_split_pkg::*;

  logic q_valid, q_pop;
  req_t q_data;
  cmd_t cmd;

  sdio_split_front #(
    .QueueDepth(QueueDepth)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .q_valid_o    (q_valid),
    .q_data_o     (q_data),
    .q_pop_i      (q_pop)
  );

  sdio_split_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_data_i   (q_data),
    .q_pop_o    (q_pop),
    .cmd_valid_o(m_axis_tvalid),
    .cmd_ready_i(m_axis_tready),
    .cmd_o      (cmd)
  );

  assign m_axis_tdata = {3'd0, cmd.offset, cmd.unit, cmd.blocks, cmd.incr, cmd.addr,
                         cmd.func, cmd.wr};
  assign m_axis_tlast = cmd.last;

  a_block_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (cmd.blocks != '0) |-> (cmd.unit == BSIZE_BIG) || (cmd.unit == BSIZE_SMALL))
    else $error("block-mode command with bad block size");

  a_unit_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (cmd.unit != '0))
    else $error("command with zero unit size");

  a_run_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid)
    else $error("command run stalled mid-request");

  a_offset_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && m_axis_tlast |=> !m_axis_tvalid || (cmd.offset == '0))
    else $error("new request does not start at buffer offset zero");

endmodule
